/* design/thermistor_table_interpolator_defines.svh */
// Assertion macros shared by the thermistor table interpolator RTL.
`ifndef THERMISTOR_TABLE_INTERPOLATOR_DEFINES_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TTI_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tti: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tti: next-cycle check failed");

`endif

/* design/tti_pkg.sv */
// Types, constants, calibration table and microcode encoding for the interpolator.
package tti_pkg;

    localparam int TABLE_ENTRIES     = 121;
    localparam int IDX_W             = $clog2(TABLE_ENTRIES);
    localparam int CNT_W             = $clog2(TABLE_ENTRIES + 1);
    localparam int READING_W         = 10;
    localparam int VALUE_W           = 17;
    localparam int OUT_W             = 17;
    localparam int OFFSET_W          = 8;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int READING_SCALE     = 100;
    localparam int PC_W              = 4;
    localparam int DATA_W            = 32;
    localparam int ADDR_W            = 3;

    localparam logic [OFFSET_W-1:0] TEMP_OFFSET_RESET = 8'd40;
    localparam logic [0:0]          REG_TEMP_OFFSET   = 1'b0;

    // Calibration values, scaled sensor readings, one per degree, non-increasing.
    localparam logic [VALUE_W-1:0] CAL_ROM [TABLE_ENTRIES] = '{
        17'd95178, 17'd94912, 17'd94634, 17'd94344, 17'd94041,
        17'd93726, 17'd93400, 17'd93060, 17'd92707, 17'd92339,
        17'd91958, 17'd91563, 17'd91154, 17'd90730, 17'd90289,
        17'd89835, 17'd89366, 17'd88880, 17'd88379, 17'd87862,
        17'd87328, 17'd86778, 17'd86212, 17'd85630, 17'd85031,
        17'd84415, 17'd83783, 17'd83135, 17'd82470, 17'd81789,
        17'd81092, 17'd80379, 17'd79651, 17'd78907, 17'd78147,
        17'd77374, 17'd76585, 17'd75782, 17'd74966, 17'd74136,
        17'd73294, 17'd72439, 17'd71572, 17'd70695, 17'd69808,
        17'd68910, 17'd68003, 17'd67088, 17'd66165, 17'd65234,
        17'd64298, 17'd63357, 17'd62409, 17'd61458, 17'd60616,
        17'd59547, 17'd58589, 17'd57629, 17'd56669, 17'd55709,
        17'd54749, 17'd53794, 17'd52839, 17'd51888, 17'd50942,
        17'd50000, 17'd49063, 17'd48133, 17'd47210, 17'd46291,
        17'd45382, 17'd44481, 17'd43589, 17'd42703, 17'd41830,
        17'd40954, 17'd40113, 17'd39269, 17'd38435, 17'd37613,
        17'd36805, 17'd36008, 17'd35221, 17'd34448, 17'd33687,
        17'd32935, 17'd31820, 17'd31092, 17'd30762, 17'd30065,
        17'd29379, 17'd28709, 17'd28047, 17'd27399, 17'd26761,
        17'd26139, 17'd25534, 17'd24936, 17'd24351, 17'd23775,
        17'd23219, 17'd22666, 17'd22131, 17'd21606, 17'd21092,
        17'd20591, 17'd20102, 17'd19621, 17'd19153, 17'd18699,
        17'd18254, 17'd17817, 17'd17390, 17'd16971, 17'd16569,
        17'd16171, 17'd15782, 17'd15060, 17'd14690, 17'd14332,
        17'd14332
    };

    localparam logic [VALUE_W-1:0] ROM_TOP    = CAL_ROM[0];
    localparam logic [VALUE_W-1:0] ROM_BOTTOM = CAL_ROM[TABLE_ENTRIES-1];

    // Datapath operations issued by the microcode.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MID,
        OP_PROBE,
        OP_NARROW,
        OP_FETCH_I,
        OP_FETCH_PREV,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT_FRAC,
        OP_EMIT_OOR,
        OP_EMIT_EXACT
    } op_t;

    // Handshake a step waits on before it executes.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_OOR,
        COND_FOUND,
        COND_EXACT,
        COND_DIV_MORE
    } cond_t;

    typedef struct packed {
        op_t             op;
        hold_t           hold;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Datapath flags returned to the sequencer.
    typedef struct packed {
        logic oor;
        logic found;
        logic exact;
        logic div_more;
        logic out_busy;
    } status_t;

    function automatic logic [VALUE_W-1:0] cal_rom_read(input logic [CNT_W-1:0] idx);
        logic [VALUE_W-1:0] data;
        data = '0;
        if (idx < CNT_W'(TABLE_ENTRIES))
        begin
            data = CAL_ROM[idx[IDX_W-1:0]];
        end
        return data;
    endfunction

endpackage

/* design/tti_sequencer.sv */
// Microcode program store and step counter driving the interpolator datapath.
module tti_sequencer
    import tti_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output logic    in_ready,
    output op_t     op
);

    localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] STEP_RANGE      = 4'd1;
    localparam logic [PC_W-1:0] STEP_MID        = 4'd2;
    localparam logic [PC_W-1:0] STEP_PROBE      = 4'd3;
    localparam logic [PC_W-1:0] STEP_NARROW     = 4'd4;
    localparam logic [PC_W-1:0] STEP_FETCH_I    = 4'd5;
    localparam logic [PC_W-1:0] STEP_FETCH_PREV = 4'd6;
    localparam logic [PC_W-1:0] STEP_DIV_INIT   = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIV        = 4'd8;
    localparam logic [PC_W-1:0] STEP_EMIT_FRAC  = 4'd9;
    localparam logic [PC_W-1:0] STEP_EMIT_OOR   = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT_EXACT = 4'd11;

    function automatic ucode_t program_word(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, hold: HOLD_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:       w = '{OP_LOAD,       HOLD_IN,   COND_NONE,     STEP_IDLE};
            STEP_RANGE:      w = '{OP_NOP,        HOLD_NONE, COND_OOR,      STEP_EMIT_OOR};
            STEP_MID:        w = '{OP_MID,        HOLD_NONE, COND_FOUND,    STEP_FETCH_I};
            STEP_PROBE:      w = '{OP_PROBE,      HOLD_NONE, COND_NONE,     STEP_IDLE};
            STEP_NARROW:     w = '{OP_NARROW,     HOLD_NONE, COND_ALWAYS,   STEP_MID};
            STEP_FETCH_I:    w = '{OP_FETCH_I,    HOLD_NONE, COND_NONE,     STEP_IDLE};
            STEP_FETCH_PREV: w = '{OP_FETCH_PREV, HOLD_NONE, COND_NONE,     STEP_IDLE};
            STEP_DIV_INIT:   w = '{OP_DIV_INIT,   HOLD_NONE, COND_EXACT,    STEP_EMIT_EXACT};
            STEP_DIV:        w = '{OP_DIV_STEP,   HOLD_NONE, COND_DIV_MORE, STEP_DIV};
            STEP_EMIT_FRAC:  w = '{OP_EMIT_FRAC,  HOLD_OUT,  COND_ALWAYS,   STEP_IDLE};
            STEP_EMIT_OOR:   w = '{OP_EMIT_OOR,   HOLD_OUT,  COND_ALWAYS,   STEP_IDLE};
            STEP_EMIT_EXACT: w = '{OP_EMIT_EXACT, HOLD_OUT,  COND_ALWAYS,   STEP_IDLE};
            default:         w = '{OP_NOP,        HOLD_NONE, COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          cw;
    logic            stall;
    logic            take;

    assign cw = program_word(pc_reg);

    always_comb
    begin
        unique case (cw.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_OOR:      take = status.oor;
            COND_FOUND:    take = status.found;
            COND_EXACT:    take = status.exact;
            COND_DIV_MORE: take = status.div_more;
            default:       take = 1'b0;
        endcase
    end

    assign stall = ((cw.hold == HOLD_IN) && !in_valid) ||
                   ((cw.hold == HOLD_OUT) && status.out_busy);

    always_comb
    begin
        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    assign op       = stall ? OP_NOP : cw.op;
    assign in_ready = (cw.hold == HOLD_IN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* design/tti_datapath.sv */
// Search registers, table read port, serial divider and result register.
module tti_datapath
    import tti_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  op_t                        op,
    input  logic [READING_W-1:0]       reading,
    input  logic [OFFSET_W-1:0]        offset,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [OUT_W-1:0]    temperature_q8,
    output logic                       out_of_range,
    output status_t                    status
);

    localparam int DCNT_W = $clog2(FRACTION_BITS + 1);

    logic [VALUE_W-1:0]       value_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         hi_reg;
    logic [CNT_W-1:0]         mid_reg;
    logic [VALUE_W-1:0]       probe_reg;
    logic [VALUE_W-1:0]       cur_reg;
    logic [VALUE_W-1:0]       prev_reg;
    logic [VALUE_W-1:0]       rem_reg;
    logic [VALUE_W-1:0]       den_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic [OUT_W-1:0]         temp_reg;
    logic                     oor_reg;
    logic                     out_valid_reg;

    logic [CNT_W-1:0]         rom_addr;
    logic [VALUE_W-1:0]       rom_data;
    logic [VALUE_W:0]         rem_shift;
    logic                     rem_fits;
    logic [CNT_W:0]           mid_sum;
    logic [OUT_W-1:0]         base_exact;
    logic [OUT_W-1:0]         base_frac;

    // One shared table read port, addressed by the current step.
    always_comb
    begin
        case (op)
            OP_FETCH_I:    rom_addr = lo_reg;
            OP_FETCH_PREV: rom_addr = lo_reg - CNT_W'(1);
            default:       rom_addr = mid_reg;
        endcase
    end

    assign rom_data   = cal_rom_read(rom_addr);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign rem_shift  = {rem_reg, 1'b0};
    assign rem_fits   = rem_shift >= {1'b0, den_reg};
    assign base_exact = OUT_W'(lo_reg) - OUT_W'(offset);
    assign base_frac  = OUT_W'(lo_reg) - OUT_W'(1) - OUT_W'(offset);

    assign status.oor      = (value_reg > ROM_TOP) || (value_reg < ROM_BOTTOM);
    assign status.found    = (lo_reg >= hi_reg);
    assign status.exact    = (cur_reg == value_reg) || (lo_reg == '0);
    assign status.div_more = (dcnt_reg > DCNT_W'(1));
    assign status.out_busy = out_valid_reg && !out_ready;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                value_reg <= VALUE_W'(reading) * VALUE_W'(READING_SCALE);
                lo_reg    <= '0;
                hi_reg    <= CNT_W'(TABLE_ENTRIES);
            end
            OP_MID:        mid_reg   <= mid_sum[CNT_W:1];
            OP_PROBE:      probe_reg <= rom_data;
            OP_NARROW:
            begin
                if (probe_reg <= value_reg)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + CNT_W'(1);
                end
            end
            OP_FETCH_I:    cur_reg  <= rom_data;
            OP_FETCH_PREV: prev_reg <= rom_data;
            OP_DIV_INIT:
            begin
                rem_reg  <= prev_reg - value_reg;
                den_reg  <= prev_reg - cur_reg;
                quo_reg  <= '0;
                dcnt_reg <= DCNT_W'(FRACTION_BITS);
            end
            OP_DIV_STEP:
            begin
                if (rem_fits)
                begin
                    rem_reg <= VALUE_W'(rem_shift - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= rem_shift[VALUE_W-1:0];
                end
                quo_reg  <= {quo_reg[FRACTION_BITS-2:0], rem_fits};
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            OP_EMIT_FRAC:
            begin
                temp_reg <= OUT_W'(base_frac << FRACTION_BITS) + OUT_W'(quo_reg);
                oor_reg  <= 1'b0;
            end
            OP_EMIT_OOR:
            begin
                temp_reg <= '0;
                oor_reg  <= 1'b1;
            end
            OP_EMIT_EXACT:
            begin
                temp_reg <= OUT_W'(base_exact << FRACTION_BITS);
                oor_reg  <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((op == OP_EMIT_FRAC) || (op == OP_EMIT_OOR) || (op == OP_EMIT_EXACT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign temperature_q8 = $signed(temp_reg);
    assign out_of_range   = oor_reg;

endmodule

/* design/thermistor_table_interpolator.sv */
// Top level of the thermistor table interpolator: register port, sequencer and datapath.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------
//  input    | in_valid/in_ready  | reading [9:0]
//  output   | out_valid/out_ready| temperature_q8 [16:0] s, out_of_range
//  config   | psel/penable/pready| paddr, pwdata, prdata (offset reg)
//
// In-range readings run a binary search of at most 7 probes over 121 entries,
// each probe one pass of the three-step table probe loop, then the
// one-bit-per-cycle restoring divider for the fraction; exact table hits skip
// the divider and out-of-range readings skip both. Reset clears the step
// counter, the result valid flag and restores temperature_offset to 40; the
// table is constant and needs no pass.
// A stalled result sits in the output register while the next reading is
// processed; the program only waits at its emit step if that register is still full.
module thermistor_table_interpolator
    import tti_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // reading transfer
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [READING_W-1:0]    reading,
    // result transfer
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] temperature_q8,
    output logic                    out_of_range,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

`include "thermistor_table_interpolator_defines.svh"

    logic [OFFSET_W-1:0] offset_reg;
    logic                reg_hit;
    logic                reg_write;
    op_t                 op;
    status_t             status;

    // Register port: single register at word 0, zero-wait accesses.
    assign reg_hit   = (paddr[ADDR_W-1:2] == REG_TEMP_OFFSET);
    assign reg_write = psel && penable && pwrite && reg_hit;
    assign pready    = 1'b1;
    assign prdata    = reg_hit ? DATA_W'(offset_reg) : '0;

    // Hold the offset; the user must change configuration only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= TEMP_OFFSET_RESET;
        end
        else if (reg_write)
        begin
            offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    // Step counter and microcode store: issues one datapath operation a cycle unless stalled on a handshake.
    tti_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    // Search registers, table read, divider and the result register.
    tti_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .reading        (reading),
        .offset         (offset_reg),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .temperature_q8 (temperature_q8),
        .out_of_range   (out_of_range),
        .status         (status)
    );

    // An out-of-range result always carries a zero temperature.
    `TTI_ASSERT_IMPLY(a_oor_zero, out_valid && out_of_range, temperature_q8 == '0)
    // Once a reading is taken the program leaves its idle step.
    `TTI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A register write lands in the offset on the following cycle.
    `TTI_ASSERT_NEXT(a_offset_write, reg_write, offset_reg == $past(pwdata[OFFSET_W-1:0]))

endmodule
